>>> design/jms_pkg.sv
// Shared types, constants and register codes for the jet multiplicity selector.
`timescale 1ns / 1ps

package jms_pkg;

    // Field widths
    localparam int PT_W       = 16;
    localparam int CNT_W      = 8;
    localparam int MASK_W     = 16;
    localparam int BOUND_W    = 9;
    localparam int THR_SLOTS  = 4;
    localparam int TCOUNT_W   = 3;
    localparam int CUT_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Parameter defaults
    localparam int NUM_THRESHOLDS_DEF = 4;
    localparam int MASK_JETS_DEF      = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CUT_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_JET_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_JET_COUNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_BTAG_COUNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BTAG_COUNT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_COUNT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PT_THRESHOLDS   = 3'd6;

    // cut_mode bit positions
    localparam int CUT_JET_BIT  = 0;
    localparam int CUT_BTAG_BIT = 1;

    // Count saturation value
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Configuration register file contents
    typedef struct packed {
        logic [CUT_W-1:0]                    cut_mode;
        logic [BOUND_W-1:0]                  min_jet_count;
        logic [BOUND_W-1:0]                  max_jet_count;
        logic [BOUND_W-1:0]                  min_btag_count;
        logic [BOUND_W-1:0]                  max_btag_count;
        logic [TCOUNT_W-1:0]                 threshold_count;
        logic [THR_SLOTS-1:0][PT_W-1:0]      pt_thresholds;
    } cfg_t;

    // Event summary handed from the accumulator to the result stage
    typedef struct packed {
        logic              emit;
        logic [CNT_W-1:0]  jet_count;
        logic [CNT_W-1:0]  btag_count;
        logic [MASK_W-1:0] btag_mask;
    } evt_t;

    // Count window check; a negative bound means no bound
    function automatic logic in_window(
        input logic [CNT_W-1:0]   n,
        input logic [BOUND_W-1:0] lo,
        input logic [BOUND_W-1:0] hi
    );
        logic lo_ok;
        logic hi_ok;
        lo_ok = lo[BOUND_W-1] || (n >= lo[CNT_W-1:0]);
        hi_ok = hi[BOUND_W-1] || (n <= hi[CNT_W-1:0]);
        return lo_ok && hi_ok;
    endfunction

endpackage

>>> design/jms_if.sv
// Channel interfaces: jet input, event result and configuration write.
`timescale 1ns / 1ps

interface jms_in_if;
    logic                     valid;
    logic                     ready;
    logic [jms_pkg::PT_W-1:0] jet_pt;
    logic                     is_btagged;
    logic                     jet_present;
    logic                     last_jet;

    modport source (output valid, jet_pt, is_btagged, jet_present, last_jet, input ready);
    modport sink   (input valid, jet_pt, is_btagged, jet_present, last_jet, output ready);
endinterface

interface jms_out_if;
    logic                       valid;
    logic                       ready;
    logic [jms_pkg::CNT_W-1:0]  jet_count;
    logic [jms_pkg::CNT_W-1:0]  btag_count;
    logic [jms_pkg::MASK_W-1:0] btag_mask;
    logic                       jets_passed;
    logic                       btags_passed;
    logic                       accept;

    modport source (output valid, jet_count, btag_count, btag_mask, jets_passed,
                    btags_passed, accept, input ready);
    modport sink   (input valid, jet_count, btag_count, btag_mask, jets_passed,
                    btags_passed, accept, output ready);
endinterface

interface jms_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [jms_pkg::CFG_IDX_W-1:0]  index;
    logic [jms_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> design/jms_cfg_regs.sv
// Configuration register file, written through the config channel.
`timescale 1ns / 1ps

module jms_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    jms_cfg_if.sink       cfg,
    output jms_pkg::cfg_t regs
);
    import jms_pkg::*;

    // Bounds reset to -1 (disabled), everything else to zero
    localparam cfg_t CFG_RST = '{
        cut_mode:        '0,
        min_jet_count:   '1,
        max_jet_count:   '1,
        min_btag_count:  '1,
        max_btag_count:  '1,
        threshold_count: '0,
        pt_thresholds:   '0
    };

    cfg_t regs_reg;
    cfg_t regs_next;

    // Always ready to take a write
    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // Register decode
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_CUT_MODE:        regs_next.cut_mode        = cfg.data[CUT_W-1:0];
                REG_MIN_JET_COUNT:   regs_next.min_jet_count   = cfg.data[BOUND_W-1:0];
                REG_MAX_JET_COUNT:   regs_next.max_jet_count   = cfg.data[BOUND_W-1:0];
                REG_MIN_BTAG_COUNT:  regs_next.min_btag_count  = cfg.data[BOUND_W-1:0];
                REG_MAX_BTAG_COUNT:  regs_next.max_btag_count  = cfg.data[BOUND_W-1:0];
                REG_THRESHOLD_COUNT: regs_next.threshold_count = cfg.data[TCOUNT_W-1:0];
                REG_PT_THRESHOLDS:   regs_next.pt_thresholds   = cfg.data;
                default:             regs_next = regs_reg;
            endcase
        end
    end

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= CFG_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

>>> design/jms_accum.sv
// Per-event accumulator: pt truncation, jet and b-tag counts, b-tag mask.
`timescale 1ns / 1ps

module jms_accum #(
    parameter int NUM_THRESHOLDS = jms_pkg::NUM_THRESHOLDS_DEF,
    parameter int MASK_JETS      = jms_pkg::MASK_JETS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     take,
    input  logic [jms_pkg::PT_W-1:0] jet_pt,
    input  logic                     is_btagged,
    input  logic                     jet_present,
    input  logic                     last_jet,
    input  jms_pkg::cfg_t            regs,
    output jms_pkg::evt_t            evt
);
    import jms_pkg::*;

    // Thresholds actually usable, and mask bits actually kept
    localparam int THR_LIM   = (NUM_THRESHOLDS < THR_SLOTS) ? NUM_THRESHOLDS : THR_SLOTS;
    localparam int MASK_BITS = (MASK_JETS < MASK_W) ? MASK_JETS : MASK_W;
    localparam int THR_IDX_W = $clog2(THR_SLOTS);

    logic [CNT_W-1:0]     jet_index_reg,      jet_index_next;
    logic                 truncated_reg,      truncated_next;
    logic [CNT_W-1:0]     accepted_jets_reg,  accepted_jets_next;
    logic [CNT_W-1:0]     accepted_btags_reg, accepted_btags_next;
    logic [MASK_BITS-1:0] btag_bits_reg,      btag_bits_next;

    logic [TCOUNT_W-1:0]  nth_eff;
    logic [PT_W-1:0]      thr;
    logic                 cut;
    logic                 keep;
    logic [CNT_W-1:0]     jets_upd;
    logic [CNT_W-1:0]     btags_upd;
    logic [MASK_BITS-1:0] bits_upd;
    logic [CNT_W-1:0]     index_upd;
    logic                 trunc_upd;

    // Threshold limit and the pt compare for this jet
    always_comb
    begin
        if (regs.threshold_count > TCOUNT_W'(THR_LIM))
            nth_eff = TCOUNT_W'(THR_LIM);
        else
            nth_eff = regs.threshold_count;
        thr = regs.pt_thresholds[jet_index_reg[THR_IDX_W-1:0]];
        cut = (jet_index_reg < CNT_W'(nth_eff)) && (jet_pt < thr);
        keep = !truncated_reg && !cut;
    end

    // Updated counts and mask for a present jet
    always_comb
    begin
        trunc_upd = truncated_reg || cut;
        jets_upd  = accepted_jets_reg;
        btags_upd = accepted_btags_reg;
        bits_upd  = btag_bits_reg;
        if (keep)
        begin
            if (accepted_jets_reg != CNT_MAX)
                jets_upd = accepted_jets_reg + CNT_W'(1);
            if (is_btagged)
            begin
                if (accepted_btags_reg != CNT_MAX)
                    btags_upd = accepted_btags_reg + CNT_W'(1);
                for (int i = 0; i < MASK_BITS; i++)
                begin
                    if (jet_index_reg == CNT_W'(i))
                        bits_upd[i] = 1'b1;
                end
            end
        end
        index_upd = (jet_index_reg != CNT_MAX) ? jet_index_reg + CNT_W'(1) : jet_index_reg;
    end

    // Event summary and next state; an empty event reports zeros
    always_comb
    begin
        evt.emit       = !jet_present || last_jet;
        evt.jet_count  = jet_present ? jets_upd  : '0;
        evt.btag_count = jet_present ? btags_upd : '0;
        evt.btag_mask  = jet_present ? MASK_W'(bits_upd) : '0;

        jet_index_next      = jet_index_reg;
        truncated_next      = truncated_reg;
        accepted_jets_next  = accepted_jets_reg;
        accepted_btags_next = accepted_btags_reg;
        btag_bits_next      = btag_bits_reg;
        if (take)
        begin
            if (evt.emit)
            begin
                jet_index_next      = '0;
                truncated_next      = 1'b0;
                accepted_jets_next  = '0;
                accepted_btags_next = '0;
                btag_bits_next      = '0;
            end
            else
            begin
                jet_index_next      = index_upd;
                truncated_next      = trunc_upd;
                accepted_jets_next  = jets_upd;
                accepted_btags_next = btags_upd;
                btag_bits_next      = bits_upd;
            end
        end
    end

    // Event state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jet_index_reg      <= '0;
            truncated_reg      <= 1'b0;
            accepted_jets_reg  <= '0;
            accepted_btags_reg <= '0;
            btag_bits_reg      <= '0;
        end
        else
        begin
            jet_index_reg      <= jet_index_next;
            truncated_reg      <= truncated_next;
            accepted_jets_reg  <= accepted_jets_next;
            accepted_btags_reg <= accepted_btags_next;
            btag_bits_reg      <= btag_bits_next;
        end
    end

endmodule

>>> design/jms_result.sv
// Result stage: count windows, accept flag and the output register.
`timescale 1ns / 1ps

module jms_result (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  jms_pkg::evt_t evt,
    input  jms_pkg::cfg_t regs,
    output logic          space,
    jms_out_if.source     result
);
    import jms_pkg::*;

    logic              valid_reg,  valid_next;
    logic [CNT_W-1:0]  jets_reg,   btags_reg;
    logic [MASK_W-1:0] mask_reg;
    logic              jp_reg,     bp_reg,   acc_reg;
    logic              jp,         bp,       acc;

    // Output register frees up when empty or being taken this cycle
    assign space = !valid_reg || result.ready;

    // Window checks and the accept decision
    always_comb
    begin
        jp  = in_window(evt.jet_count,  regs.min_jet_count,  regs.max_jet_count);
        bp  = in_window(evt.btag_count, regs.min_btag_count, regs.max_btag_count);
        acc = !(regs.cut_mode[CUT_JET_BIT] && !jp) && !(regs.cut_mode[CUT_BTAG_BIT] && !bp);
    end

    // Valid flag
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (result.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            jets_reg  <= evt.jet_count;
            btags_reg <= evt.btag_count;
            mask_reg  <= evt.btag_mask;
            jp_reg    <= jp;
            bp_reg    <= bp;
            acc_reg   <= acc;
        end
    end

    assign result.valid        = valid_reg;
    assign result.jet_count    = jets_reg;
    assign result.btag_count   = btags_reg;
    assign result.btag_mask    = mask_reg;
    assign result.jets_passed  = jp_reg;
    assign result.btags_passed = bp_reg;
    assign result.accept       = acc_reg;

endmodule

>>> design/jet_multiplicity_selector_top.sv
// Top level of the jet multiplicity selector.
// A result word is registered and appears in the cycle after the last jet word of an event is taken.
// Throughput: one jet word per cycle; the single output register stalls input only
// while a result word waits and the sink is not ready.
// Reset (rst_n, asynchronous, active low) clears the event state and the output valid;
// count bounds reset to -1 (disabled), other registers to zero.
`timescale 1ns / 1ps

module jet_multiplicity_selector_top #(
    parameter int NUM_THRESHOLDS = jms_pkg::NUM_THRESHOLDS_DEF,
    parameter int MASK_JETS      = jms_pkg::MASK_JETS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    jms_in_if.sink    jets,
    jms_out_if.source result,
    jms_cfg_if.sink   cfg
);
    import jms_pkg::*;

    cfg_t regs;
    evt_t evt;
    logic space;
    logic take;

    // Input handshake
    assign jets.ready = space;
    assign take       = jets.valid && space;

    jms_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    jms_accum #(
        .NUM_THRESHOLDS (NUM_THRESHOLDS),
        .MASK_JETS      (MASK_JETS)
    ) u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .jet_pt      (jets.jet_pt),
        .is_btagged  (jets.is_btagged),
        .jet_present (jets.jet_present),
        .last_jet    (jets.last_jet),
        .regs        (regs),
        .evt         (evt)
    );

    jms_result u_result (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (take && evt.emit),
        .evt    (evt),
        .regs   (regs),
        .space  (space),
        .result (result)
    );

endmodule
